// ===== rtl/ptf_pkg.sv =====
`default_nettype none

package ptf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_W     = 48;
    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 16;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 16;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;

    // clamped error holds +-2^(FRAC_BITS-2)
    localparam int ERR_W     = FRAC_BITS;
    localparam int DIFF_W    = DATA_W + 1;
    // product terms are limited to +-2^TERM_SH
    localparam int TERM_SH   = 40;
    localparam int TERM_W    = TERM_SH + 2;
    localparam int SUM_W     = TERM_W + 1;
    localparam int ACC_W     = SUM_W + 1;

    localparam int DIV_STEPS = ERR_W;
    localparam int MUL_STEPS = INT_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(1) << (FRAC_BITS - 2);
    localparam logic signed [DIFF_W-1:0] DIFF_LO = -DIFF_HI;

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(1) << GAIN_FRAC;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HOLD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

endpackage

`default_nettype wire

// ===== rtl/ptf_smul.sv =====
`default_nettype none

module ptf_smul (
    input  wire logic                                  i_clk,
    input  wire ptf_pkg::t_mul_ctl                     i_ctl,
    input  wire logic signed [ptf_pkg::GAIN_W-1:0]     i_gain,
    input  wire logic signed [ptf_pkg::INT_W-1:0]      i_opnd,
    output logic signed [ptf_pkg::TERM_W-1:0]          o_term
);

    localparam int GW = ptf_pkg::GAIN_W;
    localparam int OW = ptf_pkg::INT_W;
    localparam int PW = GW + OW;
    localparam int RW = PW - ptf_pkg::GAIN_FRAC;
    localparam int LW = ptf_pkg::TERM_SH;

    logic [GW-1:0] r_ag;
    logic [GW-1:0] r_acc;
    logic [OW-1:0] r_mq;
    logic          r_neg;

    logic [GW-1:0] gain_mag;
    logic [OW-1:0] opnd_mag;
    logic [GW:0]   part_sum;
    logic [PW-1:0] prod;
    logic [RW-1:0] prod_q;
    logic          over;
    logic [LW:0]   term_mag;
    logic [LW+1:0] term_ext;
    logic signed [ptf_pkg::TERM_W-1:0] n_term;

    assign gain_mag = i_gain[GW-1] ? GW'(-i_gain) : GW'(i_gain);
    assign opnd_mag = i_opnd[OW-1] ? OW'(-i_opnd) : OW'(i_opnd);

    // one multiplier bit per cycle while step is set, lsb first
    assign part_sum = {1'b0, r_acc} + (r_mq[0] ? {1'b0, r_ag} : {(GW+1){1'b0}});

    assign prod   = {r_acc, r_mq};
    assign prod_q = prod[PW-1:ptf_pkg::GAIN_FRAC];
    assign over   = (|prod_q[RW-1:LW+1]) | (prod_q[LW] & (|prod_q[LW-1:0]));

    always_comb begin
        term_mag = over ? {1'b1, {LW{1'b0}}} : prod_q[LW:0];
        term_ext = {1'b0, term_mag};
        n_term   = r_neg ? $signed(-term_ext) : $signed(term_ext);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ag  <= gain_mag;
            r_acc <= '0;
            r_mq  <= opnd_mag;
            r_neg <= i_gain[GW-1] ^ i_opnd[OW-1];
        end else if (i_ctl.step) begin
            r_acc <= part_sum[GW:1];
            r_mq  <= {part_sum[0], r_mq[OW-1:1]};
        end
        o_term <= n_term;
    end

endmodule

`default_nettype wire

// ===== rtl/pid_tracking_filter_unit.sv =====
// funcs 0 and 1 pass through the error and integrator states, the 16-step serial divider for
// the derivative, the 48-step bit-serial multipliers and the term and sum states; funcs 2 and 3
// go from the error state straight to the final state, which waits while the output is stalled;
// no beat is taken while one is in flight, the next in the cycle after the result is registered
// reset: synchronous, active low; gains return to p = 1.0, i = d = 0, loop state clears,
// step count becomes 1
`default_nettype none

module pid_tracking_filter_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [ptf_pkg::FUNC_W-1:0]             i_func,
    input  wire logic signed [ptf_pkg::DATA_W-1:0]      i_sample,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [ptf_pkg::DATA_W-1:0]           o_filtered,
    input  wire logic                                   i_cfg_we,
    input  wire logic [ptf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [ptf_pkg::GAIN_W-1:0]             i_cfg_data
);

    localparam int DW = ptf_pkg::DATA_W;
    localparam int EW = ptf_pkg::ERR_W;
    localparam int IW = ptf_pkg::INT_W;
    localparam int SW = ptf_pkg::STEP_W;
    localparam int GW = ptf_pkg::GAIN_W;
    localparam int TW = ptf_pkg::TERM_W;
    localparam int CW = ptf_pkg::CNT_W;
    localparam int UW = ptf_pkg::SUM_W;
    localparam int AW = ptf_pkg::ACC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_INT  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MLD  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_TRM  = 4'd6;
    localparam logic [3:0] S_SUM1 = 4'd7;
    localparam logic [3:0] S_SUM2 = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [ptf_pkg::FUNC_W-1:0] r_func;

    logic signed [GW-1:0] r_gain_p;
    logic signed [GW-1:0] r_gain_i;
    logic signed [GW-1:0] r_gain_d;

    logic signed [DW-1:0] r_y;
    logic signed [EW-1:0] r_prev;
    logic signed [IW-1:0] r_int;
    logic [SW-1:0]        r_steps;
    logic signed [DW-1:0] r_held;

    // payload
    logic signed [DW-1:0] r_src;
    logic signed [EW-1:0] r_err;
    logic [EW-1:0]        r_dq;
    logic [SW-1:0]        r_drem;
    logic [SW-1:0]        r_dvsr;
    logic                 r_dneg;
    logic signed [UW-1:0] r_tsum;
    logic signed [DW-1:0] r_ynew;

    logic signed [ptf_pkg::DIFF_W-1:0] diff;
    logic signed [EW-1:0] n_err;
    logic [IW:0]          int_add;
    logic signed [IW-1:0] n_int_sum;
    logic [IW-1:0]        int_rnd;
    logic signed [IW-1:0] n_int_half;
    logic [EW:0]          num;
    logic [EW-1:0]        num_mag;
    logic [SW:0]          div_t;
    logic                 div_ge;
    logic [SW:0]          div_sub;
    logic [EW:0]          q_ext;
    logic signed [EW:0]   d_val;
    logic signed [AW-1:0] y_add;
    logic signed [DW-1:0] n_ynew;
    logic                 out_free;

    ptf_pkg::t_mul_ctl    mul_ctl;
    logic signed [GW-1:0] gain_i_eff;
    logic signed [GW-1:0] gain_d_eff;
    logic signed [IW-1:0] opnd_p;
    logic signed [IW-1:0] opnd_d;
    logic signed [TW-1:0] term_p;
    logic signed [TW-1:0] term_i;
    logic signed [TW-1:0] term_d;

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !o_valid || !i_stall;

    // error against the sample, clamped to a quarter
    always_comb begin
        diff = {r_src[DW-1], r_src} - {r_y[DW-1], r_y};
        if (diff > ptf_pkg::DIFF_HI) begin
            n_err = ptf_pkg::DIFF_HI[EW-1:0];
        end else if (diff < ptf_pkg::DIFF_LO) begin
            n_err = ptf_pkg::DIFF_LO[EW-1:0];
        end else begin
            n_err = diff[EW-1:0];
        end
    end

    always_comb begin
        int_add = {r_int[IW-1], r_int} + {{(IW+1-EW){r_err[EW-1]}}, r_err};
        if (int_add[IW] != int_add[IW-1]) begin
            n_int_sum = int_add[IW] ? ptf_pkg::INT_MIN : ptf_pkg::INT_MAX;
        end else begin
            n_int_sum = int_add[IW-1:0];
        end
        // halving rounds toward zero
        int_rnd    = r_int + {{(IW-1){1'b0}}, r_int[IW-1]};
        n_int_half = {int_rnd[IW-1], int_rnd[IW-1:1]};
    end

    // restoring divider, one quotient bit per cycle in S_DIV
    always_comb begin
        num     = {r_err[EW-1], r_err} - {r_prev[EW-1], r_prev};
        num_mag = num[EW] ? EW'(-num) : num[EW-1:0];
        div_t   = {r_drem, r_dq[EW-1]};
        div_ge  = div_t >= {1'b0, r_dvsr};
        div_sub = div_ge ? (div_t - {1'b0, r_dvsr}) : div_t;
        q_ext   = {1'b0, r_dq};
        d_val   = r_dneg ? $signed(-q_ext) : $signed(q_ext);
    end

    assign mul_ctl.load = (r_state == S_MLD);
    assign mul_ctl.step = (r_state == S_MUL);
    assign gain_i_eff   = (r_func == ptf_pkg::FUNC_HOLD) ? '0 : r_gain_i;
    assign gain_d_eff   = (r_func == ptf_pkg::FUNC_HOLD) ? '0 : r_gain_d;
    assign opnd_p       = {{(IW-EW){r_err[EW-1]}}, r_err};
    assign opnd_d       = {{(IW-EW-1){d_val[EW]}}, d_val};

    ptf_smul u_mul_p (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_gain (r_gain_p),
        .i_opnd (opnd_p),
        .o_term (term_p)
    );

    ptf_smul u_mul_i (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_gain (gain_i_eff),
        .i_opnd (r_int),
        .o_term (term_i)
    );

    ptf_smul u_mul_d (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_gain (gain_d_eff),
        .i_opnd (opnd_d),
        .o_term (term_d)
    );

    always_comb begin
        y_add = AW'(r_y) + AW'(r_tsum);
        if (y_add[AW-1:DW-1] != {(AW-DW+1){1'b0}}
                && y_add[AW-1:DW-1] != {(AW-DW+1){1'b1}}) begin
            n_ynew = y_add[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            n_ynew = y_add[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_func   <= ptf_pkg::FUNC_SAMPLE;
            o_valid  <= 1'b0;
            r_gain_p <= ptf_pkg::GAIN_P_RESET;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_y      <= '0;
            r_prev   <= '0;
            r_int    <= '0;
            r_steps  <= ptf_pkg::STEP_ONE;
            r_held   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ptf_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data;
                    ptf_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data;
                    ptf_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data;
                    default: ;
                endcase
            end

            // in S_FIN the output register is refilled below
            if (o_valid && !i_stall && r_state != S_FIN) begin
                o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_func;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    case (r_func)
                        ptf_pkg::FUNC_INIT: begin
                            r_int   <= '0;
                            r_prev  <= '0;
                            r_held  <= '0;
                            r_steps <= ptf_pkg::STEP_ONE;
                            r_state <= S_FIN;
                        end
                        ptf_pkg::FUNC_NOP: r_state <= S_FIN;
                        default:           r_state <= S_INT;
                    endcase
                end
                S_INT: begin
                    if (r_func == ptf_pkg::FUNC_SAMPLE) begin
                        r_int   <= n_int_sum;
                        r_prev  <= r_err;
                        r_steps <= ptf_pkg::STEP_ONE;
                        r_held  <= r_src;
                    end else begin
                        r_int <= n_int_half;
                        if (r_steps != ptf_pkg::STEP_MAX) begin
                            r_steps <= r_steps + ptf_pkg::STEP_ONE;
                        end
                    end
                    r_cnt   <= CW'(ptf_pkg::DIV_STEPS - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MLD;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_MLD: begin
                    r_cnt   <= CW'(ptf_pkg::MUL_STEPS - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= S_TRM;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_TRM:  r_state <= S_SUM1;
                S_SUM1: r_state <= S_SUM2;
                S_SUM2: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_y     <= r_ynew;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_src <= (i_func == ptf_pkg::FUNC_HOLD) ? r_held : i_sample;
            end
            S_ERR: begin
                r_err <= n_err;
                if (r_func == ptf_pkg::FUNC_INIT) begin
                    r_ynew <= r_src;
                end else begin
                    r_ynew <= r_y;
                end
            end
            S_INT: begin
                // divisor is the step count before this beat
                r_dq   <= num_mag;
                r_drem <= '0;
                r_dvsr <= r_steps;
                r_dneg <= num[EW];
            end
            S_DIV: begin
                r_drem <= div_sub[SW-1:0];
                r_dq   <= {r_dq[EW-2:0], div_ge};
            end
            S_SUM1: begin
                r_tsum <= UW'(term_p) + UW'(term_i) + UW'(term_d);
            end
            S_SUM2: begin
                r_ynew <= n_ynew;
            end
            S_FIN: begin
                if (out_free) begin
                    o_filtered <= r_ynew;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ptf_checker.sv =====
`default_nettype none

module ptf_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_valid,
    input wire logic                                   o_stall,
    input wire logic [ptf_pkg::FUNC_W-1:0]             i_func,
    input wire logic signed [ptf_pkg::DATA_W-1:0]      i_sample,
    input wire logic                                   o_valid,
    input wire logic                                   i_stall,
    input wire logic signed [ptf_pkg::DATA_W-1:0]      o_filtered
);

    logic in_beat;

    assign in_beat = i_valid && !o_stall;

    // an accepted beat keeps the input side busy until its result is out
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_stall)
        else $error("input not stalled after an accepted beat");

    // a result only appears while an item is in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without an item in flight");

    // initialize, accepted while no result is held, echoes its sample through the error and final states
    a_init_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_func == ptf_pkg::FUNC_INIT && !o_valid)
            |=> ##2 (o_valid && o_filtered == $past(i_sample, 3)))
        else $error("initialize result wrong");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_filtered)))
        else $error("stalled output beat changed");

endmodule

bind pid_tracking_filter_unit ptf_checker u_ptf_checker (.*);

`default_nettype wire
